/* hdl/triangle_fan_index_batcher_top_macros.svh */
// Assertion macros shared by the batcher's checker.
`ifndef TRIANGLE_FAN_INDEX_BATCHER_TOP_MACROS_SVH
`define TRIANGLE_FAN_INDEX_BATCHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TFIB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TFIB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tfib_pkg.sv */
// Shared types and constants of the triangle fan index batcher.
package tfib_pkg;

	localparam int POLY_W    = 7;
	localparam int SLOT_W    = 16;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 1;
	localparam int SUM_W     = CFG_W + 1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_CAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_CAP  = 1'b1;

	localparam logic [CFG_W-1:0] VERTEX_CAP_RST = 20'd4096;
	localparam logic [CFG_W-1:0] INDEX_CAP_RST  = 20'd12288;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_BAD_COUNT = 3'd1,
		ST_NO_VROOM  = 3'd2,
		ST_NO_IROOM  = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	typedef struct packed {
		logic [CFG_W-1:0] vert_slots;
		logic [CFG_W-1:0] idx_slots;
	} cfg_t;

	typedef struct packed {
		logic [CFG_W-1:0] a;
		logic [CFG_W-1:0] b;
		logic [CFG_W-1:0] limit;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             gt;
	} alu_rsp_t;

endpackage

/* hdl/tfib_cmd_if.sv */
// Command channel: valid/ready handshake carrying one batch command.
interface tfib_cmd_if import tfib_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [POLY_W-1:0] polygon_vertices;

	modport source (output valid, output command, output polygon_vertices, input ready);
	modport sink   (input valid, input command, input polygon_vertices, output ready);
endinterface

/* hdl/tfib_res_if.sv */
// Result channel: valid/ready handshake carrying one fan result.
interface tfib_res_if import tfib_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [SLOT_W-1:0] slot_base;
	logic              triangle_valid;
	logic [SLOT_W-1:0] corner_a;
	logic [SLOT_W-1:0] corner_b;
	logic [SLOT_W-1:0] corner_c;
	logic              last;
	logic              flush_hint;

	modport source (output valid, output status, output slot_base, output triangle_valid,
		output corner_a, output corner_b, output corner_c, output last,
		output flush_hint, input ready);
	modport sink   (input valid, input status, input slot_base, input triangle_valid,
		input corner_a, input corner_b, input corner_c, input last,
		input flush_hint, output ready);
endinterface

/* hdl/triangle_fan_index_batcher_top.sv */
// Top level of the triangle fan index batcher: sequencer around one shared adder.
//
// One command at a time is taken from the command channel; cmd.ready is high only while
// the sequencer is idle. Every step runs through a single add-and-compare unit: vertex
// room check, index room check, two flush-headroom compares, first-corner set-up, then
// one corner add per triangle beat. An accepted add of N >= 3 vertices gives N - 2
// result beats, one per cycle while res.ready stays high; other commands give one beat.
// A clear or a bad vertex count skips both room checks, and a refusal for lack of vertex
// room skips the index check. Results leave through an output register, so the next
// command is taken while the final beat still waits. The vertex limit is the configured
// vertex slot count clamped to ADDRESSABLE_VERTICES; the flush hint compares against the
// unclamped value. Configuration writes are taken any time, but belong only to an idle
// block.
module triangle_fan_index_batcher_top import tfib_pkg::*; #(
	parameter int MAX_POLYGON_VERTICES = 64,
	parameter int ADDRESSABLE_VERTICES = 65536,
	parameter int FLUSH_HEADROOM       = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	tfib_cmd_if.sink             cmd,
	tfib_res_if.source           res
);

	// vertices_used never exceeds the addressable limit
	localparam int VU_W   = $clog2(ADDRESSABLE_VERTICES + 1);
	localparam int TRI_W  = $clog2(MAX_POLYGON_VERTICES - 1);
	localparam int NEED_W = $clog2(3 * (MAX_POLYGON_VERTICES - 2) + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_VCHK,
		S_ICHK,
		S_FLV,
		S_FLI,
		S_PREP,
		S_EMIT
	} state_t;

	state_t            state_q;
	cfg_t              cfg;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	logic [POLY_W-1:0] n_q;
	logic [NEED_W-1:0] need_q;
	logic [TRI_W-1:0]  tri_left_q;
	logic [VU_W-1:0]   vused_q;
	logic [VU_W-1:0]   vsum_q;
	logic [CFG_W-1:0]  iused_q;
	status_t           status_q;
	logic [SLOT_W-1:0] base_q;
	logic [SLOT_W-1:0] next_q;
	logic              vflag_q;
	logic              flush_q;

	// output register
	logic              out_valid_q;
	status_t           o_status_q;
	logic [SLOT_W-1:0] o_base_q;
	logic              o_tri_q;
	logic [SLOT_W-1:0] o_a_q;
	logic [SLOT_W-1:0] o_b_q;
	logic [SLOT_W-1:0] o_c_q;
	logic              o_last_q;
	logic              o_flush_q;

	logic              cmd_beat;
	logic              n_bad;
	logic [POLY_W-1:0] tris_n;
	logic [TRI_W-1:0]  tris;
	logic [NEED_W-1:0] need;
	logic [CFG_W-1:0]  vlimit;
	logic              out_free;
	logic              out_load;

	tfib_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tfib_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_beat  = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	// a result beat is loaded into the output register this cycle
	assign out_load  = (state_q == S_EMIT) && out_free;

	// polygon size decode at accept time
	assign n_bad  = (cmd.polygon_vertices == '0) ||
		(cmd.polygon_vertices > POLY_W'(MAX_POLYGON_VERTICES));
	assign tris_n = (cmd.polygon_vertices >= POLY_W'(3)) ? cmd.polygon_vertices - POLY_W'(2)
		: '0;
	assign tris   = TRI_W'(tris_n);
	assign need   = NEED_W'({tris, 1'b0}) + NEED_W'(tris);

	assign vlimit = (cfg.vert_slots > CFG_W'(ADDRESSABLE_VERTICES)) ?
		CFG_W'(ADDRESSABLE_VERTICES) : cfg.vert_slots;

	// operand select for the shared unit
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			S_VCHK: begin
				alu_req.a     = CFG_W'(vused_q);
				alu_req.b     = CFG_W'(n_q);
				alu_req.limit = vlimit;
			end
			S_ICHK: begin
				alu_req.a     = iused_q;
				alu_req.b     = CFG_W'(need_q);
				alu_req.limit = cfg.idx_slots;
			end
			S_FLV: begin
				alu_req.a     = CFG_W'(vused_q);
				alu_req.b     = CFG_W'(FLUSH_HEADROOM);
				alu_req.limit = cfg.vert_slots;
			end
			S_FLI: begin
				alu_req.a     = iused_q;
				alu_req.b     = CFG_W'(3 * FLUSH_HEADROOM);
				alu_req.limit = cfg.idx_slots;
			end
			S_PREP: begin
				alu_req.a = CFG_W'(base_q);
				alu_req.b = CFG_W'(1);
			end
			S_EMIT: begin
				alu_req.a = CFG_W'(next_q);
				alu_req.b = CFG_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vused_q     <= '0;
			iused_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// held beat stays until taken; a new one is loaded when the register frees
			out_valid_q <= out_load || (out_valid_q && !res.ready);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_beat) begin
						n_q    <= cmd.polygon_vertices;
						need_q <= need;
						if (cmd.command == CMD_CLEAR) begin
							vused_q    <= '0;
							iused_q    <= '0;
							status_q   <= ST_CLEARED;
							tri_left_q <= '0;
							state_q    <= S_FLV;
						end else if (n_bad) begin
							status_q   <= ST_BAD_COUNT;
							tri_left_q <= '0;
							state_q    <= S_FLV;
						end else begin
							tri_left_q <= tris;
							state_q    <= S_VCHK;
						end
					end
				end
				S_VCHK: begin
					if (alu_rsp.gt) begin
						status_q   <= ST_NO_VROOM;
						tri_left_q <= '0;
						state_q    <= S_FLV;
					end else begin
						vsum_q  <= alu_rsp.sum[VU_W-1:0];
						state_q <= S_ICHK;
					end
				end
				S_ICHK: begin
					if (alu_rsp.gt) begin
						status_q   <= ST_NO_IROOM;
						tri_left_q <= '0;
					end else begin
						// commit the polygon
						status_q <= ST_ACCEPTED;
						base_q   <= SLOT_W'(vused_q);
						vused_q  <= vsum_q;
						iused_q  <= alu_rsp.sum[CFG_W-1:0];
					end
					state_q <= S_FLV;
				end
				S_FLV: begin
					vflag_q <= alu_rsp.gt;
					state_q <= S_FLI;
				end
				S_FLI: begin
					flush_q <= vflag_q || alu_rsp.gt;
					state_q <= S_PREP;
				end
				S_PREP: begin
					next_q  <= alu_rsp.sum[SLOT_W-1:0];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						o_status_q  <= status_q;
						o_base_q    <= (status_q == ST_ACCEPTED) ? base_q : '0;
						o_flush_q   <= flush_q;
						if (tri_left_q == '0) begin
							// refusal, clear or a polygon with no triangle
							o_tri_q  <= 1'b0;
							o_a_q    <= '0;
							o_b_q    <= '0;
							o_c_q    <= '0;
							o_last_q <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							o_tri_q    <= 1'b1;
							o_a_q      <= base_q;
							o_b_q      <= next_q;
							o_c_q      <= alu_rsp.sum[SLOT_W-1:0];
							o_last_q   <= (tri_left_q == TRI_W'(1));
							next_q     <= alu_rsp.sum[SLOT_W-1:0];
							tri_left_q <= tri_left_q - TRI_W'(1);
							if (tri_left_q == TRI_W'(1)) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid          = out_valid_q;
	assign res.status         = o_status_q;
	assign res.slot_base      = o_base_q;
	assign res.triangle_valid = o_tri_q;
	assign res.corner_a       = o_a_q;
	assign res.corner_b       = o_b_q;
	assign res.corner_c       = o_c_q;
	assign res.last           = o_last_q;
	assign res.flush_hint     = o_flush_q;

endmodule

/* hdl/tfib_alu.sv */
// Shared add-and-compare unit: sum of two operands and sum > limit.
module tfib_alu import tfib_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [SUM_W-1:0] sum;

	assign sum     = {1'b0, req.a} + {1'b0, req.b};
	assign rsp.sum = sum;
	assign rsp.gt  = sum > {1'b0, req.limit};

endmodule

/* hdl/tfib_cfg.sv */
// Configuration registers: vertex and index capacity.
module tfib_cfg import tfib_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vert_slots <= VERTEX_CAP_RST;
			cfg_q.idx_slots  <= INDEX_CAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERTEX_CAP: cfg_q.vert_slots <= cfg_wdata;
				CFG_INDEX_CAP:  cfg_q.idx_slots  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/tfib_checker.sv */
// Port-level checker for the batcher, bound to the top level.
`include "triangle_fan_index_batcher_top_macros.svh"

module tfib_checker import tfib_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [2:0]        res_status,
	input logic [SLOT_W-1:0] res_slot_base,
	input logic              res_triangle_valid,
	input logic [SLOT_W-1:0] res_corner_a,
	input logic [SLOT_W-1:0] res_corner_b,
	input logic [SLOT_W-1:0] res_corner_c,
	input logic              res_last,
	input logic              res_flush_hint
);

	`TFIB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_slot_base) && $stable(res_corner_b) && $stable(res_last) && $stable(res_flush_hint), "stalled result beat changed")
	`TFIB_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")
	`TFIB_ASSERT_SAME(a_fan_shape, res_valid && res_triangle_valid, res_status == ST_ACCEPTED && res_corner_a == res_slot_base && res_corner_c == res_corner_b + 16'd1 && res_corner_b > res_corner_a, "bad fan triangle")
	`TFIB_ASSERT_SAME(a_single_last, res_valid && !res_triangle_valid, res_last && res_corner_a == '0 && res_corner_b == '0 && res_corner_c == '0, "non-triangle beat not final")
	`TFIB_ASSERT_SAME(a_refused_base, res_valid && res_status != ST_ACCEPTED, res_slot_base == '0 && !res_triangle_valid, "refused beat carries a slot")

endmodule

bind triangle_fan_index_batcher_top tfib_checker u_tfib_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cmd_valid          (cmd.valid),
	.cmd_ready          (cmd.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_status         (res.status),
	.res_slot_base      (res.slot_base),
	.res_triangle_valid (res.triangle_valid),
	.res_corner_a       (res.corner_a),
	.res_corner_b       (res.corner_b),
	.res_corner_c       (res.corner_c),
	.res_last           (res.last),
	.res_flush_hint     (res.flush_hint)
);

/* tb/tfib_fan_checker.sv */
// Checker for the triangle fan index batcher: predicts every result beat and compares it.
module tfib_fan_checker import tfib_pkg::*; #(
	parameter int MAX_POLYGON_VERTICES = 64,
	parameter int ADDRESSABLE_VERTICES = 65536,
	parameter int FLUSH_HEADROOM       = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	tfib_cmd_if                  cmd,
	tfib_res_if                  res,
	output int unsigned          mismatches,
	output int unsigned          pending,
	output int unsigned          compared
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_base;
		logic              triangle_valid;
		logic [SLOT_W-1:0] corner_a;
		logic [SLOT_W-1:0] corner_b;
		logic [SLOT_W-1:0] corner_c;
		logic              last;
		logic              flush_hint;
	} fan_beat_t;

	fan_beat_t        fan_q[$];
	logic [CFG_W-1:0] vertex_cap;
	logic [CFG_W-1:0] index_cap;
	logic [16:0]      verts_used;
	logic [CFG_W-1:0] idx_used;
	int unsigned      report_budget = 40;

	function automatic logic low_headroom();
		return (32'(verts_used) + 32'(FLUSH_HEADROOM) > 32'(vertex_cap)) ||
			(32'(idx_used) + 32'(3 * FLUSH_HEADROOM) > 32'(index_cap));
	endfunction

	// Applies one command to the local copy of the batch and queues its result beats.
	function automatic void predict_fan(logic op, logic [POLY_W-1:0] nverts);
		fan_beat_t   beat;
		int unsigned vlimit;
		int unsigned tris;
		int unsigned need;
		int unsigned base;
		beat = '0;
		beat.last = 1'b1;
		vlimit = (32'(vertex_cap) > ADDRESSABLE_VERTICES) ? ADDRESSABLE_VERTICES
			: 32'(vertex_cap);
		tris = (nverts >= 3) ? 32'(nverts) - 2 : 0;
		need = 3 * tris;
		base = 32'(verts_used);
		if (op == CMD_CLEAR) begin
			verts_used = '0;
			idx_used = '0;
			beat.status = ST_CLEARED;
		end else if (nverts == 0 || nverts > MAX_POLYGON_VERTICES) begin
			beat.status = ST_BAD_COUNT;
		end else if (base + 32'(nverts) > vlimit) begin
			beat.status = ST_NO_VROOM;
		end else if (32'(idx_used) + need > 32'(index_cap)) begin
			beat.status = ST_NO_IROOM;
		end else begin
			verts_used = 17'(base + 32'(nverts));
			idx_used = CFG_W'(32'(idx_used) + need);
			beat.status = ST_ACCEPTED;
			beat.slot_base = SLOT_W'(base);
		end
		beat.flush_hint = low_headroom();
		if (beat.status == ST_ACCEPTED && tris != 0) begin
			for (int unsigned k = 0; k < tris; k++) begin
				beat.triangle_valid = 1'b1;
				beat.corner_a = SLOT_W'(base);
				beat.corner_b = SLOT_W'(base + 1 + k);
				beat.corner_c = SLOT_W'(base + 2 + k);
				beat.last = (k + 1 == tris);
				fan_q.push_back(beat);
			end
		end else begin
			fan_q.push_back(beat);
		end
	endfunction

	function automatic logic field_differs(string label, logic [15:0] want, logic [15:0] got);
		if (got === want)
			return 1'b0;
		if (report_budget != 0) begin
			report_budget--;
			$display("%0t ns: %s expected %0d, actual %0d", $time, label, want, got);
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		fan_beat_t want;
		logic      bad;
		if (!arst_n) begin
			vertex_cap = VERTEX_CAP_RST;
			index_cap = INDEX_CAP_RST;
			verts_used = '0;
			idx_used = '0;
			fan_q.delete();
			mismatches <= 0;
			pending <= 0;
			compared <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_VERTEX_CAP)
					vertex_cap = cfg_wdata;
				else if (cfg_index == CFG_INDEX_CAP)
					index_cap = cfg_wdata;
			end
			if (res.valid && res.ready) begin
				if (fan_q.size() == 0) begin
					if (report_budget != 0) begin
						report_budget--;
						$display("%0t ns: result beat expected none, actual status %0d base %0d",
							$time, res.status, res.slot_base);
					end
					mismatches <= mismatches + 1;
				end else begin
					want = fan_q.pop_front();
					bad = field_differs("status", 16'(want.status), 16'(res.status)) |
						field_differs("slot_base", want.slot_base, res.slot_base) |
						field_differs("triangle_valid", 16'(want.triangle_valid),
							16'(res.triangle_valid)) |
						field_differs("corner_a", want.corner_a, res.corner_a) |
						field_differs("corner_b", want.corner_b, res.corner_b) |
						field_differs("corner_c", want.corner_c, res.corner_c) |
						field_differs("last", 16'(want.last), 16'(res.last)) |
						field_differs("flush_hint", 16'(want.flush_hint), 16'(res.flush_hint));
					compared <= compared + 1;
					if (bad)
						mismatches <= mismatches + 1;
				end
			end
			if (cmd.valid && cmd.ready)
				predict_fan(cmd.command, cmd.polygon_vertices);
			pending <= fan_q.size();
		end
	end

endmodule

/* tb/tb.sv */
// Top level testbench of the triangle fan index batcher: stimulus, idling and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tfib_pkg::*;

	// Generous watchdog: far above any correct run, even with every beat stalled.
	localparam int unsigned RUN_LIMIT = 2_000_000;
	localparam int          SEGMENTS  = 8;
	localparam int          SEG_BEATS = 25;

	// Capacity settings per random segment; the extremes of both registers are among them.
	localparam int unsigned SEG_VCAP [SEGMENTS] =
		'{4096, 0, 1048575, 200, 96, 1048575, 40, 65536};
	localparam int unsigned SEG_ICAP [SEGMENTS] =
		'{12288, 0, 1048575, 300, 1048575, 120, 60, 65535};
	// Idling mix per segment, in percent: sender idle and receiver stall.
	localparam int unsigned SEG_IDLE [SEGMENTS]  = '{0, 82, 0, 19, 0, 82, 0, 19};
	localparam int unsigned SEG_STALL [SEGMENTS] = '{0, 0, 82, 19, 0, 0, 82, 19};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_VERTEX_CAP;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_op = CMD_ADD;
	logic [POLY_W-1:0]    cmd_nverts = '0;
	logic                 res_ready = 1'b0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;
	int unsigned commands_sent = 0;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned compared;

	tfib_cmd_if cmd_ch ();
	tfib_res_if res_ch ();

	// All stimulus goes through local variables so every input is known from time zero.
	assign cmd_ch.valid            = cmd_valid;
	assign cmd_ch.command          = cmd_op;
	assign cmd_ch.polygon_vertices = cmd_nverts;
	assign res_ch.ready            = res_ready;

	triangle_fan_index_batcher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	tfib_fan_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: ready is redrawn every falling edge against the current stall rate.
	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung handshake or a missing result beat ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Every task below is entered and left just after a falling edge, so valid is
	// assigned at most once per step: it only drops when a gap is actually drawn.
	task automatic send_command(logic op, logic [POLY_W-1:0] nverts);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_op <= op;
		cmd_nverts <= nverts;
		// Ready is sampled at the rising edge, before the block updates it.
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
		commands_sent++;
	endtask

	// Sender holds off until every predicted beat has come back, then waits out the settle delay.
	task automatic wait_idle(int unsigned settle);
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// Both registers are written back to back; only ever called on an idle block.
	task automatic write_caps(int unsigned vcap, int unsigned icap);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VERTEX_CAP;
		cfg_wdata <= CFG_W'(vcap);
		@(negedge clk);
		cfg_index <= CFG_INDEX_CAP;
		cfg_wdata <= CFG_W'(icap);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic              op;
		logic [POLY_W-1:0] nverts;
		int unsigned       pick;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset capacities: clear with junk count, bad counts (zero, just over
		// the maximum, all ones), one and two vertices with no triangles, the smallest
		// fan, a quad, the largest polygon, a pentagon, then a clear with a zero count.
		send_command(CMD_CLEAR, 7'd127);
		send_command(CMD_ADD, 7'd0);
		send_command(CMD_ADD, 7'd65);
		send_command(CMD_ADD, 7'd127);
		send_command(CMD_ADD, 7'd1);
		send_command(CMD_ADD, 7'd2);
		send_command(CMD_ADD, 7'd3);
		send_command(CMD_ADD, 7'd4);
		send_command(CMD_ADD, 7'd64);
		send_command(CMD_ADD, 7'd5);
		send_command(CMD_CLEAR, 7'd0);

		// Tight batch: index room runs out before vertex room and the other way round.
		wait_idle(10);
		write_caps(10, 9);
		send_command(CMD_ADD, 7'd8);
		send_command(CMD_ADD, 7'd11);
		send_command(CMD_ADD, 7'd3);
		send_command(CMD_ADD, 7'd2);
		send_command(CMD_ADD, 7'd5);
		send_command(CMD_ADD, 7'd6);
		send_command(CMD_CLEAR, 7'd64);
		send_command(CMD_ADD, 7'd10);

		// Empty batch: every add with a valid count is refused for vertex room.
		wait_idle(10);
		write_caps(0, 0);
		send_command(CMD_ADD, 7'd1);
		send_command(CMD_ADD, 7'd0);
		send_command(CMD_CLEAR, 7'd1);

		// Random segments, one capacity setting and one idling mix each.
		for (int s = 0; s < SEGMENTS; s++) begin
			wait_idle(10);
			write_caps(SEG_VCAP[s], SEG_ICAP[s]);
			idle_pct = SEG_IDLE[s];
			stall_pct <= SEG_STALL[s];
			for (int k = 0; k < SEG_BEATS; k++) begin
				// Mostly well-formed small fans; some large ones, clears and bad counts.
				pick = $urandom_range(99);
				op = CMD_ADD;
				if (pick < 5) begin
					op = CMD_CLEAR;
					nverts = POLY_W'($urandom_range(127));
				end else if (pick < 12) begin
					nverts = POLY_W'($urandom_range(127));
				end else if (pick < 22) begin
					nverts = POLY_W'($urandom_range(2, 1));
				end else if (pick < 75) begin
					nverts = POLY_W'($urandom_range(8, 3));
				end else if (pick < 92) begin
					nverts = POLY_W'($urandom_range(64, 9));
				end else begin
					nverts = POLY_W'($urandom_range(127, 65));
				end
				// Mid-segment hold-off in every other segment: the pipe drains completely.
				if (s % 2 == 1 && k == SEG_BEATS / 2)
					wait_idle(0);
				send_command(op, nverts);
			end
		end

		wait_idle(20);
		$display("summary: %0d commands over %0d capacity settings and idle/stall mixes",
			commands_sent, SEGMENTS + 3);
		$display("summary: %0d result beats compared field by field", compared);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
